// File: rtl/core/ik1_pkg.sv
package ik1_pkg;

  localparam int D_W      = 17;
  localparam int K_W      = 25;
  localparam int O_W      = 19;
  localparam int T_W      = 44;
  localparam int N_W      = T_W - 32;
  localparam int E_W      = 63;
  localparam int EXP_N    = 4;
  localparam int TAYLOR_N = 12;
  localparam int RECIP_W  = 36;
  localparam int RECIP_SH = 35;
  localparam int EXP_LAT  = 2 * TAYLOR_N + 2;
  localparam int ALPHA_QW = 31;
  localparam int ANUM_W   = 61;
  localparam int GATE_QW  = 17;
  localparam int GNUM_W   = 63;
  localparam int S_W      = 46;
  localparam int NORM_MAX = 18;
  localparam int CUR_W    = 24;
  localparam int TOTAL_LAT = 2 + EXP_LAT + ALPHA_QW + 5 + GATE_QW + 3;

  localparam int LANE_A  = 0;
  localparam int LANE_B1 = 1;
  localparam int LANE_B2 = 2;
  localparam int LANE_C  = 3;

  localparam logic [E_W-1:0]    SAT_CAP   = E_W'(1) << 62;
  localparam logic [E_W-1:0]    Q30_ONE   = E_W'(1) << 30;
  localparam logic [29:0]       LN2_Q30   = 30'd744261118;
  localparam logic [ANUM_W-1:0] ALPHA_NUM = {31'd1095216660, 30'd0};
  localparam logic [29:0]       B1_SCALE  = 30'd527464934;

  localparam logic signed [K_W-1:0] K_TAB [EXP_N] =
    '{25'sd5772751, 25'sd1944098, 25'sd1494622, -25'sd12448326};
  localparam logic signed [O_W-1:0] O_TAB [EXP_N] =
    '{-19'sd15159, 19'sd1402, -19'sd152143, 19'sd1217};

  localparam logic signed [15:0] REV_RESET  = -16'sd22515;
  localparam logic [15:0]        COND_RESET = 16'd2477;

  typedef enum logic [0:0] {
    REG_REVERSAL   = 1'b0,
    REG_CONDUCTANCE = 1'b1
  } cfg_reg_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] i);
    unique case (i)
      4'd1:    recip = 36'd34359738368;
      4'd2:    recip = 36'd17179869184;
      4'd3:    recip = 36'd11453246123;
      4'd4:    recip = 36'd8589934592;
      4'd5:    recip = 36'd6871947674;
      4'd6:    recip = 36'd5726623062;
      4'd7:    recip = 36'd4908534053;
      4'd8:    recip = 36'd4294967296;
      4'd9:    recip = 36'd3817748708;
      4'd10:   recip = 36'd3435973837;
      4'd11:   recip = 36'd3123612579;
      4'd12:   recip = 36'd2863311531;
      default: recip = '0;
    endcase
  endfunction

endpackage

// File: rtl/core/ik1_exp2.sv
module ik1_exp2 (
  input  logic                          clk,
  input  logic signed [ik1_pkg::T_W-1:0] t,
  output logic [ik1_pkg::E_W-1:0]       value
);
  import ik1_pkg::*;

  localparam int TERM_W = 31;
  localparam int SUM_W  = 32;
  localparam int Y_W    = 30;
  localparam int PA_W   = TERM_W + Y_W;
  localparam int PB_W   = TERM_W + RECIP_W;
  localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << 30;

  logic [Y_W-1:0]    y0;
  logic [N_W-1:0]    n0;
  logic [TERM_W-1:0] a_prod [TAYLOR_N];
  logic [SUM_W-1:0]  a_sum  [TAYLOR_N];
  logic [Y_W-1:0]    a_y    [TAYLOR_N];
  logic [N_W-1:0]    a_n    [TAYLOR_N];
  logic [TERM_W-1:0] b_term [TAYLOR_N];
  logic [SUM_W-1:0]  b_sum  [TAYLOR_N];
  logic [Y_W-1:0]    b_y    [TAYLOR_N];
  logic [N_W-1:0]    b_n    [TAYLOR_N];

  logic [TERM_W-1:0] t_in [TAYLOR_N];
  logic [SUM_W-1:0]  s_in [TAYLOR_N];
  logic [Y_W-1:0]    y_in [TAYLOR_N];
  logic [N_W-1:0]    n_in [TAYLOR_N];
  logic [TERM_W-1:0] prod_next [TAYLOR_N];
  logic [TERM_W-1:0] term_next [TAYLOR_N];

  logic [SUM_W-1:0] sum_f;
  logic [N_W-1:0]   n_f;
  logic [N_W-1:0]   nmag;
  logic             neg;
  logic             big;
  logic             tiny;
  logic [63:0]      up;
  logic [SUM_W-1:0] dn;
  logic [E_W-1:0]   value_next;

  always_comb begin
    t_in[0] = TERM_ONE;
    s_in[0] = '0;
    y_in[0] = y0;
    n_in[0] = n0;
    for (int k = 1; k < TAYLOR_N; k++) begin
      t_in[k] = b_term[k-1];
      s_in[k] = b_sum[k-1];
      y_in[k] = b_y[k-1];
      n_in[k] = b_n[k-1];
    end
    for (int k = 0; k < TAYLOR_N; k++) begin
      prod_next[k] = TERM_W'((PA_W'(t_in[k]) * PA_W'(y_in[k])) >> 30);
      term_next[k] = TERM_W'((PB_W'(a_prod[k]) * PB_W'(recip(4'(k + 1)))) >> RECIP_SH);
    end
  end

  always_comb begin
    sum_f = b_sum[TAYLOR_N-1] + SUM_W'(b_term[TAYLOR_N-1]);
    n_f   = b_n[TAYLOR_N-1];
    neg   = n_f[N_W-1];
    big   = !neg && (|n_f[N_W-2:5]);
    nmag  = -n_f;
    tiny  = neg && (nmag >= N_W'(63));
    up    = 64'(sum_f) << n_f[4:0];
    dn    = sum_f >> nmag[5:0];
    if (big) begin
      value_next = SAT_CAP;
    end else if (!neg) begin
      value_next = (up > 64'(SAT_CAP)) ? SAT_CAP : up[E_W-1:0];
    end else if (tiny) begin
      value_next = '0;
    end else begin
      value_next = E_W'(dn);
    end
  end

  always_ff @(posedge clk) begin
    y0 <= Y_W'((64'(t[31:0]) * 64'(LN2_Q30)) >> 32);
    n0 <= t[T_W-1:32];
    for (int k = 0; k < TAYLOR_N; k++) begin
      a_prod[k] <= prod_next[k];
      a_sum[k]  <= s_in[k] + SUM_W'(t_in[k]);
      a_y[k]    <= y_in[k];
      a_n[k]    <= n_in[k];
      b_term[k] <= term_next[k];
      b_sum[k]  <= a_sum[k];
      b_y[k]    <= a_y[k];
      b_n[k]    <= a_n[k];
    end
    value <= value_next;
  end

endmodule

// File: rtl/core/ik1_div.sv
module ik1_div #(
  parameter int NUM_W  = 8,
  parameter int DEN_W  = 8,
  parameter int QUO_W  = 4,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CW = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  logic [QUO_W-1:0]  vld;
  logic [NUM_W-1:0]  rem    [QUO_W];
  logic [DEN_W-1:0]  den_s  [QUO_W];
  logic [QUO_W-1:0]  quo_s  [QUO_W];
  logic [SIDE_W-1:0] side_s [QUO_W];

  logic [NUM_W-1:0]  rem_in   [QUO_W];
  logic [DEN_W-1:0]  den_in   [QUO_W];
  logic [QUO_W-1:0]  quo_in   [QUO_W];
  logic [NUM_W-1:0]  rem_next [QUO_W];
  logic [QUO_W-1:0]  quo_next [QUO_W];

  always_comb begin
    rem_in[0] = num;
    den_in[0] = den;
    quo_in[0] = '0;
    for (int s = 1; s < QUO_W; s++) begin
      rem_in[s] = rem[s-1];
      den_in[s] = den_s[s-1];
      quo_in[s] = quo_s[s-1];
    end
    for (int s = 0; s < QUO_W; s++) begin
      rem_next[s] = rem_in[s];
      quo_next[s] = quo_in[s];
      if ((CW'(rem_in[s]) >> (QUO_W - 1 - s)) >= CW'(den_in[s])) begin
        rem_next[s] = rem_in[s] - NUM_W'(CW'(den_in[s]) << (QUO_W - 1 - s));
        quo_next[s][QUO_W-1-s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[QUO_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_s[0] <= in_side;
    for (int s = 0; s < QUO_W; s++) begin
      rem[s]   <= rem_next[s];
      den_s[s] <= den_in[s];
      quo_s[s] <= quo_next[s];
    end
    for (int s = 1; s < QUO_W; s++) begin
      side_s[s] <= side_s[s-1];
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign quo       = quo_s[QUO_W-1];
  assign out_side  = side_s[QUO_W-1];

endmodule

// File: rtl/core/cardiac_ik1_current_core.sv
// IK1 potassium current (Luo-Rudy 1991 form), fully pipelined.
// Input: pulse start with membrane_voltage while busy is low; that beat is
// taken at the clock edge. A new voltage may be taken in every cycle.
// Output: done is high for exactly one cycle with gate_value and
// current_value; the receiver takes the beat at the edge ending that cycle.
// Throughput: one result per cycle. The four exponentials each run
// through a 26-stage series pipeline, alpha comes from a 31-stage
// one-bit-per-stage divider and the gate from a 17-stage divider; these
// make up most of the pipeline. Five stages of products and
// normalization and three stages for the current complete the chain.
// Configuration: cfg_write with cfg_index and cfg_data writes the reversal
// potential (index 0) or the conductance (index 1); write only while no
// beat is in flight.
// Reset: synchronous; empties the pipeline, restores both registers to
// their defaults, and holds busy high while rst is high.
module cardiac_ik1_current_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [15:0]                 membrane_voltage,
  input  logic                               cfg_write,
  input  logic [0:0]                         cfg_index,
  input  logic [15:0]                        cfg_data,
  output logic                               done,
  output logic [15:0]                        gate_value,
  output logic signed [ik1_pkg::CUR_W-1:0]   current_value
);
  import ik1_pkg::*;

  localparam int ASIDE_W = D_W + 3 * E_W;
  localparam int GSIDE_W = D_W + 1;
  localparam logic [63:0] NORM_LIMIT = 64'(1) << S_W;

  logic signed [15:0] reversal_potential;
  logic [15:0]        conductance;

  logic                    v1;
  logic signed [D_W-1:0]   d1;
  logic signed [O_W-1:0]   dx [EXP_N];
  logic signed [T_W-1:0]   t_lane [EXP_N];
  logic [E_W-1:0]          e_lane [EXP_N];
  logic [EXP_LAT:0]        line_v;
  logic signed [D_W-1:0]   line_d [EXP_LAT+1];

  logic                    av;
  logic [ALPHA_QW-1:0]     alpha;
  logic [ASIDE_W-1:0]      aside;
  logic signed [D_W-1:0]   ad;
  logic [E_W-1:0]          ac;
  logic [E_W-1:0]          ab1;
  logic [E_W-1:0]          ab2;
  logic [E_W-1:0]          a_ext;

  logic                    mv;
  logic signed [D_W-1:0]   md;
  logic [E_W-1:0]          mb2;
  logic [63:0]             ph;
  logic [30:0]             pl;
  logic [62:0]             qh;
  logic [29:0]             ql;

  logic [64:0]             psum;
  logic [63:0]             q1sum;
  logic [E_W-1:0]          q1;
  logic [63:0]             qsum;
  logic                    nv;
  logic signed [D_W-1:0]   nd;
  logic [E_W-1:0]          p;
  logic [E_W-1:0]          q;

  logic [NORM_MAX:0]       fl_next;
  logic                    fv;
  logic signed [D_W-1:0]   fd;
  logic [E_W-1:0]          fp;
  logic [E_W-1:0]          fq;
  logic [NORM_MAX:0]       fl;

  logic [4:0]              ksel;
  logic [S_W-1:0]          pn_next;
  logic [S_W-1:0]          sn_next;
  logic                    hv;
  logic signed [D_W-1:0]   hd;
  logic [S_W-1:0]          pn;
  logic [S_W-1:0]          sn;

  logic                    jv;
  logic signed [D_W-1:0]   jd;
  logic                    jz;
  logic [GNUM_W-1:0]       jnum;
  logic [S_W-1:0]          jden;

  logic                    gv;
  logic [GATE_QW-1:0]      gquo;
  logic [GSIDE_W-1:0]      gside;
  logic signed [D_W-1:0]   gd;
  logic                    gz;
  logic [GATE_QW-1:0]      gate_next;
  logic [15:0]             mag_next;

  logic                    cv;
  logic                    cneg;
  logic [15:0]             cmag;
  logic [GATE_QW-1:0]      cgate;
  logic [32:0]             cgm;

  logic                    xv;
  logic                    xneg;
  logic [GATE_QW-1:0]      xgate;
  logic [48:0]             xprod;

  logic [21:0]             rnd;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      reversal_potential <= REV_RESET;
      conductance        <= COND_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REVERSAL:    reversal_potential <= cfg_data;
        REG_CONDUCTANCE: conductance        <= cfg_data;
      endcase
    end
  end

  always_comb begin
    for (int g = 0; g < EXP_N; g++) begin
      dx[g] = O_W'(d1) + O_TAB[g];
    end
  end

  for (genvar g = 0; g < EXP_N; g++) begin : g_exp
    ik1_exp2 u_exp (
      .clk   (clk),
      .t     (t_lane[g]),
      .value (e_lane[g])
    );
  end

  ik1_div #(
    .NUM_W  (ANUM_W),
    .DEN_W  (E_W),
    .QUO_W  (ALPHA_QW),
    .SIDE_W (ASIDE_W)
  ) u_alpha_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (line_v[EXP_LAT]),
    .num       (ALPHA_NUM),
    .den       (Q30_ONE + e_lane[LANE_A]),
    .in_side   ({line_d[EXP_LAT], e_lane[LANE_C], e_lane[LANE_B1], e_lane[LANE_B2]}),
    .out_valid (av),
    .quo       (alpha),
    .out_side  (aside)
  );

  assign {ad, ac, ab1, ab2} = aside;
  assign a_ext = Q30_ONE + ac;

  always_comb begin
    psum  = 65'(ph) + 65'(pl);
    q1sum = 64'(qh) + 64'(ql);
    q1    = (q1sum > 64'(SAT_CAP)) ? SAT_CAP : q1sum[E_W-1:0];
    qsum  = 64'(q1) + 64'(mb2);
    for (int k = 0; k <= NORM_MAX; k++) begin
      fl_next[k] = (64'(p >> k) + 64'(q >> k)) < NORM_LIMIT;
    end
  end

  always_comb begin
    ksel = 5'(NORM_MAX);
    for (int k = NORM_MAX; k >= 0; k--) begin
      if (fl[k]) begin
        ksel = 5'(k);
      end
    end
    pn_next = S_W'(fp >> ksel);
    sn_next = S_W'(fp >> ksel) + S_W'(fq >> ksel);
  end

  ik1_div #(
    .NUM_W  (GNUM_W),
    .DEN_W  (S_W),
    .QUO_W  (GATE_QW),
    .SIDE_W (GSIDE_W)
  ) u_gate_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (jv),
    .num       (jnum),
    .den       (jden),
    .in_side   ({jd, jz}),
    .out_valid (gv),
    .quo       (gquo),
    .out_side  (gside)
  );

  assign {gd, gz} = gside;

  always_comb begin
    gate_next = gz ? '0 : gquo;
    mag_next  = 16'(gd[D_W-1] ? -gd : gd);
    rnd       = 22'((50'(xprod) + (50'(1) << 27)) >> 28);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      line_v <= '0;
      mv     <= 1'b0;
      nv     <= 1'b0;
      fv     <= 1'b0;
      hv     <= 1'b0;
      jv     <= 1'b0;
      cv     <= 1'b0;
      xv     <= 1'b0;
      done   <= 1'b0;
    end else begin
      v1     <= start && !busy;
      line_v <= {line_v[EXP_LAT-1:0], v1};
      mv     <= av;
      nv     <= mv;
      fv     <= nv;
      hv     <= fv;
      jv     <= hv;
      cv     <= gv;
      xv     <= cv;
      done   <= xv;
    end
  end

  always_ff @(posedge clk) begin
    d1 <= D_W'(membrane_voltage) - D_W'(reversal_potential);

    for (int g = 0; g < EXP_N; g++) begin
      t_lane[g] <= T_W'(K_TAB[g]) * T_W'(dx[g]);
    end
    line_d[0] <= d1;
    for (int k = 1; k <= EXP_LAT; k++) begin
      line_d[k] <= line_d[k-1];
    end

    md  <= ad;
    mb2 <= ab2;
    ph  <= 64'(a_ext[E_W-1:30]) * 64'(alpha);
    pl  <= 31'((61'(a_ext[29:0]) * 61'(alpha)) >> 30);
    qh  <= 63'(ab1[E_W-1:30]) * 63'(B1_SCALE);
    ql  <= 30'((60'(ab1[29:0]) * 60'(B1_SCALE)) >> 30);

    nd <= md;
    p  <= (psum > 65'(SAT_CAP)) ? SAT_CAP : psum[E_W-1:0];
    q  <= (qsum > 64'(SAT_CAP)) ? SAT_CAP : qsum[E_W-1:0];

    fd <= nd;
    fp <= p;
    fq <= q;
    fl <= fl_next;

    hd <= fd;
    pn <= pn_next;
    sn <= sn_next;

    jd   <= hd;
    jz   <= (sn == '0);
    jnum <= (GNUM_W'(pn) << 16) + GNUM_W'(sn >> 1);
    jden <= sn;

    cneg  <= gd[D_W-1];
    cmag  <= mag_next;
    cgate <= gate_next;
    cgm   <= 33'(conductance) * 33'(gate_next);

    xneg  <= cneg;
    xgate <= cgate;
    xprod <= 49'(cgm) * 49'(cmag);

    // rounded magnitude stays below 2^22, inside the signed 24-bit range
    gate_value    <= xgate[GATE_QW-1] ? 16'hFFFF : xgate[15:0];
    current_value <= xneg ? -CUR_W'(rnd) : CUR_W'(rnd);
  end

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOTAL_LAT))
    else $error("result beat without a matching input beat");

  a_zero_gate: assert property (@(posedge clk) disable iff (rst)
    (done && gate_value == 16'd0) |-> (current_value == '0))
    else $error("nonzero current with closed gate");

  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result beat right after reset");

endmodule
